>>> hw/rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants
// Action codes, command word and table entry layout for the sighting table.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam logic [1:0] ACT_SIGHT  = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_LIST   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [3:0]  OUT_MAX       = 4'd8;
  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

  typedef struct packed {
    logic               walk;
    logic               expire;
    logic [3:0]         limit;
    logic [15:0]        major;
    logic [15:0]        minor;
    logic signed [7:0]  rssi;
    logic [47:0]        now;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        major;
    logic [15:0]        minor;
    logic signed [7:0]  rssi;
    logic [47:0]        seen;
  } entry_t;

endpackage

>>> hw/rtl/bst_ram.sv
// ----------------------------------------------------------------------------
// bst_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bst_cmd_queue.sv
// ----------------------------------------------------------------------------
// bst_cmd_queue: command front end
// Accepts words, classifies the action and holds up to two commands.
// ----------------------------------------------------------------------------
module bst_cmd_queue
  import bst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [15:0]        beacon_major,
  input  logic [15:0]        beacon_minor,
  input  logic signed [7:0]  signal_strength,
  input  logic [47:0]        now_ms,
  input  logic [3:0]         list_limit,
  output cmd_t               q_cmd,
  output logic               q_valid,
  input  logic               q_pop
);

  cmd_t       slot [2];
  cmd_t       cmd_in;
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  always_comb begin
    cmd_in.walk   = (action != ACT_SIGHT);
    cmd_in.expire = (action == ACT_REPORT);
    if (action == ACT_LIST) begin
      cmd_in.limit = (list_limit > OUT_MAX) ? OUT_MAX : list_limit;
    end else begin
      cmd_in.limit = OUT_MAX;
    end
    cmd_in.major  = beacon_major;
    cmd_in.minor  = beacon_minor;
    cmd_in.rssi   = signal_strength;
    cmd_in.now    = now_ms;
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy && (action != ACT_NONE);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= cmd_in;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> hw/rtl/bst_engine.sv
// ----------------------------------------------------------------------------
// bst_engine: table back end
// Scans the table one entry per cycle to apply sightings and run walks.
// ----------------------------------------------------------------------------
module bst_engine
  import bst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               q_cmd,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [31:0]        timeout_ms,
  output logic               result_strobe,
  output logic               has_entry,
  output logic [15:0]        entry_major,
  output logic [15:0]        entry_minor,
  output logic signed [7:0]  entry_strength,
  output logic               last_result
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);
  localparam int EW = $bits(entry_t);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]              state;
  cmd_t                    cmd;
  logic [CW-1:0]           cnt;
  logic [IW-1:0]           p_idx;
  logic [TABLE_ENTRIES-1:0] valid;
  logic                    found;
  logic [IW-1:0]           m_idx;
  logic                    free_found;
  logic [IW-1:0]           f_idx;
  logic                    o_have;
  logic [IW-1:0]           o_idx;
  logic [47:0]             o_time;
  logic [3:0]              n;
  logic                    pend_vld;
  logic [15:0]             pend_major;
  logic [15:0]             pend_minor;
  logic signed [7:0]       pend_rssi;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  entry_t                  ram_wdata;
  logic [EW-1:0]           ram_rdata;
  entry_t                  rd;
  logic                    proc;
  logic                    e_valid;
  logic                    key_hit;
  logic [48:0]             diff;
  logic                    stale;
  logic                    emit;
  logic                    result_strobe_next;

  bst_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd        = entry_t'(ram_rdata);
    proc      = (state == ST_SCAN) && (cnt != '0);
    e_valid   = valid[p_idx];
    key_hit   = (rd.major == cmd.major) && (rd.minor == cmd.minor);
    diff      = {1'b0, cmd.now} - {1'b0, rd.seen};
    stale     = !diff[48] && (diff[47:0] > {16'd0, timeout_ms});
    emit      = proc && cmd.walk && e_valid && !stale && (n < cmd.limit);
    result_strobe_next = (emit && pend_vld) || ((state == ST_FINISH) && cmd.walk);
    q_pop     = (state == ST_IDLE) && q_valid;
    ram_we    = (state == ST_FINISH) && !cmd.walk;
    ram_waddr = found ? m_idx : (free_found ? f_idx : o_idx);
    ram_wdata.major = cmd.major;
    ram_wdata.minor = cmd.minor;
    ram_wdata.rssi  = cmd.rssi;
    ram_wdata.seen  = cmd.now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= result_strobe_next;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            cnt        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            o_have     <= 1'b0;
            pend_vld   <= 1'b0;
            n          <= 4'd0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          p_idx <= cnt[IW-1:0];
          cnt   <= cnt + 1'b1;
          if (proc) begin
            if (cmd.walk) begin
              if (e_valid && stale && cmd.expire) begin
                valid[p_idx] <= 1'b0;
              end
              if (emit) begin
                if (pend_vld) begin
                  has_entry      <= 1'b1;
                  entry_major    <= pend_major;
                  entry_minor    <= pend_minor;
                  entry_strength <= pend_rssi;
                  last_result    <= 1'b0;
                end
                pend_vld   <= 1'b1;
                pend_major <= rd.major;
                pend_minor <= rd.minor;
                pend_rssi  <= rd.rssi;
                n          <= n + 4'd1;
              end
            end else begin
              if (e_valid && key_hit && !found) begin
                found <= 1'b1;
                m_idx <= p_idx;
              end
              if (!e_valid && !free_found) begin
                free_found <= 1'b1;
                f_idx      <= p_idx;
              end
              if (!o_have || (rd.seen < o_time)) begin
                o_have <= 1'b1;
                o_idx  <= p_idx;
                o_time <= rd.seen;
              end
            end
          end
          if (cnt == LAST_CNT) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.walk) begin
            has_entry      <= pend_vld;
            entry_major    <= pend_vld ? pend_major : 16'd0;
            entry_minor    <= pend_vld ? pend_minor : 16'd0;
            entry_strength <= pend_vld ? pend_rssi : 8'sd0;
            last_result    <= 1'b1;
          end else begin
            valid[ram_waddr] <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_result |-> state == ST_IDLE)
    else $error("last result while a walk is still running");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !has_entry |-> last_result)
    else $error("empty result not marked last");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> n <= cmd.limit)
    else $error("walk emitted more entries than its limit");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == ST_SCAN)
    else $error("command popped without starting a scan");

  a_no_strobe_after_reset: assert property (@(posedge clk)
    rst |=> !result_strobe)
    else $error("result strobe right after reset");

endmodule

>>> hw/rtl/beacon_sighting_table_top.sv
// ----------------------------------------------------------------------------
// beacon_sighting_table_top: beacon sighting table
// Front queue of commands feeding a table engine with expiry and listing.
// ----------------------------------------------------------------------------
// Each command runs through the engine as a pop from the queue, a scan of every
// entry over the entry RAM read port, and a finish step that writes or reports.
// The engine takes a new command only after the finish step; a two-deep queue
// takes bursts. Walk results come at most one per cycle; the last is registered
// from the finish step, and the receiver cannot stall. Reset empties the table
// and queue and loads timeout_ms 10000.
module beacon_sighting_table_top
  import bst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [15:0]        beacon_major,
  input  logic [15:0]        beacon_minor,
  input  logic signed [7:0]  signal_strength,
  input  logic [47:0]        now_ms,
  input  logic [3:0]         list_limit,
  input  logic               timeout_we,
  input  logic [31:0]        timeout_wdata,
  output logic               result_strobe,
  output logic               has_entry,
  output logic [15:0]        entry_major,
  output logic [15:0]        entry_minor,
  output logic signed [7:0]  entry_strength,
  output logic               last_result
);

  logic [31:0] timeout_ms;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (timeout_we) begin
      timeout_ms <= timeout_wdata;
    end
  end

  bst_cmd_queue u_queue (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .beacon_major    (beacon_major),
    .beacon_minor    (beacon_minor),
    .signal_strength (signal_strength),
    .now_ms          (now_ms),
    .list_limit      (list_limit),
    .q_cmd           (q_cmd),
    .q_valid         (q_valid),
    .q_pop           (q_pop)
  );

  bst_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .q_cmd          (q_cmd),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .timeout_ms     (timeout_ms),
    .result_strobe  (result_strobe),
    .has_entry      (has_entry),
    .entry_major    (entry_major),
    .entry_minor    (entry_minor),
    .entry_strength (entry_strength),
    .last_result    (last_result)
  );

endmodule
